// ===== rtl/assert_macros.svh =====
// Assertion helpers, compiled away in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising edge outside reset.
`define ASSERT_PROP(lbl, c, r, p) \
  lbl: assert property (@(posedge c) disable iff (!r) (p)) else $error("assertion failed");
// Check that b holds on the edge after a.
`define ASSERT_NEXT(lbl, c, r, a, b) \
  lbl: assert property (@(posedge c) disable iff (!r) (a) |=> (b)) else $error("assertion failed");
`else
`define ASSERT_PROP(lbl, c, r, p)
`define ASSERT_NEXT(lbl, c, r, a, b)
`endif
`endif

// ===== rtl/sha256_pkg.sv =====
`default_nettype none
package sha256_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
  } in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_t;

  // working variables a..h, index 0 is a
  typedef logic [7:0][31:0] wv_t;

  typedef struct packed {
    logic       byte_en;
    logic [7:0] byte_val;
    logic       round_en;
  } sched_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LEN,
    ST_COMP,
    ST_FOLD,
    ST_OUT
  } state_t;

  localparam logic [7:0] PAD_MARK      = 8'h80;
  localparam logic [7:0] PAD_ZERO      = 8'h00;
  localparam logic [5:0] POS_LEN_START = 6'd56;
  localparam logic [5:0] POS_LAST      = 6'd63;
  localparam logic [5:0] RND_LAST      = 6'd63;
  localparam logic [2:0] LAST_WORD_IDX = 3'd7;

  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sig0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sig1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

  function automatic logic [31:0] init_hash(input logic [2:0] i);
    logic [31:0] h;
    case (i)
      3'd0: h = 32'h6a09e667;
      3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372;
      3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f;
      3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab;
      3'd7: h = 32'h5be0cd19;
      default: h = 32'h0;
    endcase
    return h;
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] r);
    logic [31:0] k;
    case (r)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/sha256_sched.sv =====
`default_nettype none
// Block buffer and message schedule window in one 512-bit shift line.
module sha256_sched (
  input  wire logic                   clk,
  input  wire sha256_pkg::sched_ctl_t ctl,
  output logic [31:0]                 w0
);

  logic [511:0] blk_r;
  logic [31:0]  w_new;

  // word i of the window sits at blk_r[511-32*i -: 32]
  assign w0 = blk_r[511:480];

  assign w_new = sha256_pkg::small_sig1(blk_r[511-32*14 -: 32]) + blk_r[511-32*9 -: 32]
               + sha256_pkg::small_sig0(blk_r[511-32*1 -: 32]) + blk_r[511:480];

  always_ff @(posedge clk) begin
    if (ctl.byte_en) begin
      blk_r <= {blk_r[503:0], ctl.byte_val};
    end else if (ctl.round_en) begin
      blk_r <= {blk_r[479:0], w_new};
    end
  end

endmodule
`default_nettype wire

// ===== rtl/sha256_round.sv =====
`default_nettype none
// One compression round on the working variables.
module sha256_round (
  input  wire sha256_pkg::wv_t v,
  input  wire logic [31:0]     k_word,
  input  wire logic [31:0]     w_word,
  output sha256_pkg::wv_t      v_nxt
);

  logic [31:0] ch;
  logic [31:0] maj;
  logic [31:0] t1;
  logic [31:0] t2;

  assign ch  = (v[4] & v[5]) ^ (~v[4] & v[6]);
  assign maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
  assign t1  = v[7] + sha256_pkg::big_sig1(v[4]) + ch + k_word + w_word;
  assign t2  = sha256_pkg::big_sig0(v[0]) + maj;

  always_comb begin
    v_nxt[7] = v[6];
    v_nxt[6] = v[5];
    v_nxt[5] = v[4];
    v_nxt[4] = v[3] + t1;
    v_nxt[3] = v[2];
    v_nxt[2] = v[1];
    v_nxt[1] = v[0];
    v_nxt[0] = t1 + t2;
  end

endmodule
`default_nettype wire

// ===== rtl/sha256_message_hasher_core.sv =====
// SHA-256 of a byte stream. Message bytes shift into the block buffer; the 64th byte
// of a block adds the rounds and a chaining add on one shared round unit (in_ready low).
// A last item adds padding/length shifts before each of its one or two
// compressions, then eight digest words, one per out handshake; in_ready is low meanwhile.
// Synchronous active-low reset: idle, length zero, chaining state at the initial hash.
`default_nettype none
`include "assert_macros.svh"
module sha256_message_hasher_core (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire sha256_pkg::in_t   in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output sha256_pkg::out_t       out_data
);

  sha256_pkg::state_t     state_r, state_nxt;
  sha256_pkg::state_t     ret_r, ret_nxt;    // where to go after the chaining add
  logic [5:0]             pos_r;             // byte slot in the block buffer
  logic [60:0]            cnt_r;             // message length in bytes
  logic [5:0]             rnd_r;             // round counter
  logic [2:0]             idx_r;             // digest word being shown
  logic                   pad_first_r;       // next pad byte is the 0x80 marker
  logic [31:0]            chain_r [8];
  sha256_pkg::wv_t        wv_r;
  sha256_pkg::wv_t        wv_round;
  sha256_pkg::sched_ctl_t sched_ctl;
  logic [31:0]            w0;
  logic [63:0]            len_bits;
  logic [7:0]             len_byte;
  logic                   in_acc;
  logic                   out_acc;
  logic                   comp_start;

  assign in_acc   = in_valid && in_ready;
  assign out_acc  = out_valid && out_ready;
  assign len_bits = {cnt_r, 3'b000};
  // slots 56..63 take the length most significant byte first
  assign len_byte = len_bits[{~pos_r[2:0], 3'b000} +: 8];
  assign comp_start = (state_nxt == sha256_pkg::ST_COMP) && (state_r != sha256_pkg::ST_COMP);

  sha256_sched u_sched (
    .clk (clk),
    .ctl (sched_ctl),
    .w0  (w0)
  );

  sha256_round u_round (
    .v      (wv_r),
    .k_word (sha256_pkg::round_k(rnd_r)),
    .w_word (w0),
    .v_nxt  (wv_round)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    case (state_r)
      sha256_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_data.has_byte && (pos_r == sha256_pkg::POS_LAST)) begin
            // full block: compress, then pad if this also ends the message
            state_nxt = sha256_pkg::ST_COMP;
            ret_nxt   = in_data.last ? sha256_pkg::ST_PAD : sha256_pkg::ST_IDLE;
          end else if (in_data.last) begin
            state_nxt = sha256_pkg::ST_PAD;
          end
        end
      end
      sha256_pkg::ST_PAD: begin
        if (!pad_first_r && (pos_r == sha256_pkg::POS_LEN_START)) begin
          state_nxt = sha256_pkg::ST_LEN;
        end else if (pos_r == sha256_pkg::POS_LAST) begin
          // marker left no room for the length: spare block follows
          state_nxt = sha256_pkg::ST_COMP;
          ret_nxt   = sha256_pkg::ST_PAD;
        end
      end
      sha256_pkg::ST_LEN: begin
        if (pos_r == sha256_pkg::POS_LAST) begin
          state_nxt = sha256_pkg::ST_COMP;
          ret_nxt   = sha256_pkg::ST_OUT;
        end
      end
      sha256_pkg::ST_COMP: begin
        if (rnd_r == sha256_pkg::RND_LAST) begin
          state_nxt = sha256_pkg::ST_FOLD;
        end
      end
      sha256_pkg::ST_FOLD: begin
        state_nxt = ret_r;
      end
      sha256_pkg::ST_OUT: begin
        if (out_acc && (idx_r == sha256_pkg::LAST_WORD_IDX)) begin
          state_nxt = sha256_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sha256_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs and buffer control
  always_comb begin
    in_ready              = 1'b0;
    out_valid             = 1'b0;
    sched_ctl.byte_en     = 1'b0;
    sched_ctl.byte_val    = in_data.data_byte;
    sched_ctl.round_en    = 1'b0;
    out_data.digest_word  = chain_r[idx_r];
    out_data.word_index   = idx_r;
    out_data.last_word    = (idx_r == sha256_pkg::LAST_WORD_IDX);
    case (state_r)
      sha256_pkg::ST_IDLE: begin
        in_ready          = 1'b1;
        sched_ctl.byte_en = in_valid && in_data.has_byte;
      end
      sha256_pkg::ST_PAD: begin
        sched_ctl.byte_en  = pad_first_r || (pos_r != sha256_pkg::POS_LEN_START);
        sched_ctl.byte_val = pad_first_r ? sha256_pkg::PAD_MARK : sha256_pkg::PAD_ZERO;
      end
      sha256_pkg::ST_LEN: begin
        sched_ctl.byte_en  = 1'b1;
        sched_ctl.byte_val = len_byte;
      end
      sha256_pkg::ST_COMP: begin
        sched_ctl.round_en = 1'b1;
      end
      sha256_pkg::ST_OUT: begin
        out_valid = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sha256_pkg::ST_IDLE;
      ret_r       <= sha256_pkg::ST_IDLE;
      pos_r       <= '0;
      cnt_r       <= '0;
      rnd_r       <= '0;
      idx_r       <= '0;
      pad_first_r <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        chain_r[i] <= sha256_pkg::init_hash(3'(i));
      end
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      // advance the slot on every byte shifted into the buffer
      if (sched_ctl.byte_en) begin
        pos_r <= pos_r + 6'd1;
      end
      if (in_acc && in_data.has_byte) begin
        cnt_r <= cnt_r + 61'd1;
      end
      if (in_acc && in_data.last) begin
        pad_first_r <= 1'b1;
      end else if ((state_r == sha256_pkg::ST_PAD) && sched_ctl.byte_en) begin
        pad_first_r <= 1'b0;
      end
      // wraps back to zero after the last round
      if (state_r == sha256_pkg::ST_COMP) begin
        rnd_r <= rnd_r + 6'd1;
      end
      if (state_r == sha256_pkg::ST_FOLD) begin
        idx_r <= '0;
        for (int i = 0; i < 8; i++) begin
          chain_r[i] <= chain_r[i] + wv_r[i];
        end
      end
      if (out_acc) begin
        idx_r <= idx_r + 3'd1;
        // digest delivered: drop the chaining state and length for the next message
        if (idx_r == sha256_pkg::LAST_WORD_IDX) begin
          cnt_r <= '0;
          for (int i = 0; i < 8; i++) begin
            chain_r[i] <= sha256_pkg::init_hash(3'(i));
          end
        end
      end
    end
  end

  // Working variables: load from the chaining state, then one round a cycle
  always_ff @(posedge clk) begin
    if (comp_start) begin
      for (int i = 0; i < 8; i++) begin
        wv_r[i] <= chain_r[i];
      end
    end else if (state_r == sha256_pkg::ST_COMP) begin
      wv_r <= wv_round;
    end
  end

  `ASSERT_PROP(a_no_in_during_out, clk, rst_n, !(in_ready && out_valid))
  `ASSERT_NEXT(a_comp_from_round0, clk, rst_n, comp_start, rnd_r == 6'd0)
  `ASSERT_PROP(a_out_block_aligned, clk, rst_n, !out_valid || (pos_r == 6'd0))
  `ASSERT_NEXT(a_idle_after_digest, clk, rst_n, out_acc && out_data.last_word, in_ready)

endmodule
`default_nettype wire
